>>> hw/rtl/heap_builder_top_defines.svh
// Assertion macros for the heap builder top level.
`ifndef HEAP_BUILDER_TOP_DEFINES_SVH
`define HEAP_BUILDER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define HB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hb_pkg.sv
// Shared types and constants of the heap builder.
package hb_pkg;

  localparam int KEY_WIDTH     = 32;
  localparam int DEFAULT_DEPTH = 64;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic                 last;
  } in_word_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] heap_key;
    logic                 is_last;
    logic                 overflowed;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_PAR_RD,
    ST_PAR_CAP,
    ST_LEFT_RD,
    ST_RIGHT_RD,
    ST_DECIDE,
    ST_NEXT_PAR,
    ST_EMIT_RD,
    ST_EMIT_CAP
  } hb_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_en;
    logic start;
    logic par_rd;
    logic par_cap;
    logic left_rd;
    logic right_rd;
    logic decide;
    logic next_par;
    logic emit_rd;
    logic emit_cap;
  } hb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_in;
    logic count_ge2;
    logic has_left;
    logic keep_node;
    logic parent_zero;
    logic out_free;
    logic emit_done;
  } hb_stat_t;

endpackage

>>> hw/rtl/hb_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module hb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/hb_ctrl.sv
// Controller state machine: load, bottom-up sift-down, emission.
module hb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  hb_pkg::hb_stat_t stat,
  output hb_pkg::hb_cmd_t  cmd
);
  import hb_pkg::*;

  hb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (stat.last_in) state_next = ST_START;
      ST_START:    state_next = stat.count_ge2 ? ST_PAR_RD : ST_EMIT_RD;
      ST_PAR_RD:   state_next = ST_PAR_CAP;
      ST_PAR_CAP:  state_next = ST_LEFT_RD;
      ST_LEFT_RD:  state_next = stat.has_left ? ST_RIGHT_RD : ST_NEXT_PAR;
      ST_RIGHT_RD: state_next = ST_DECIDE;
      ST_DECIDE:   state_next = stat.keep_node ? ST_NEXT_PAR : ST_LEFT_RD;
      ST_NEXT_PAR: state_next = stat.parent_zero ? ST_EMIT_RD : ST_PAR_RD;
      ST_EMIT_RD:  if (stat.out_free) state_next = ST_EMIT_CAP;
      ST_EMIT_CAP: state_next = stat.emit_done ? ST_LOAD : ST_EMIT_RD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_LOAD:     cmd.load_en  = 1'b1;
      ST_START:    cmd.start    = 1'b1;
      ST_PAR_RD:   cmd.par_rd   = 1'b1;
      ST_PAR_CAP:  cmd.par_cap  = 1'b1;
      ST_LEFT_RD:  cmd.left_rd  = 1'b1;
      ST_RIGHT_RD: cmd.right_rd = 1'b1;
      ST_DECIDE:   cmd.decide   = 1'b1;
      ST_NEXT_PAR: cmd.next_par = 1'b1;
      ST_EMIT_RD:  cmd.emit_rd  = 1'b1;
      ST_EMIT_CAP: cmd.emit_cap = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/hb_dp.sv
// Datapath: key store, sift-down registers, order register, output word.
module hb_dp #(
  parameter int DEPTH = hb_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  hb_pkg::hb_cmd_t   cmd,
  output hb_pkg::hb_stat_t  stat,
  input  logic              in_valid,
  input  hb_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output hb_pkg::out_word_t out_word,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);
  import hb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count;
  logic                 drop;
  logic                 order_is_max;
  logic [AW-1:0]        parent;
  logic [AW-1:0]        node;
  logic [AW-1:0]        idx;
  logic [KEY_WIDTH-1:0] v;
  logic [KEY_WIDTH-1:0] lval;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [KEY_WIDTH-1:0] rdata;

  logic [AW+1:0]        left_w;
  logic [AW+1:0]        right_w;
  logic                 has_left;
  logic                 has_right;
  logic                 pick_left;
  logic                 pick_right;
  logic [KEY_WIDTH-1:0] pv;
  logic [KEY_WIDTH-1:0] best;
  logic [AW-1:0]        pick_idx;
  logic                 full;
  logic                 load_acc;
  logic                 emit_done;
  logic                 out_take;

  // parent value p must give way to child value c
  function automatic logic out_of_order(input logic is_max,
                                        input logic [KEY_WIDTH-1:0] p,
                                        input logic [KEY_WIDTH-1:0] c);
    return is_max ? (p < c) : (p > c);
  endfunction

  assign left_w    = {1'b0, node, 1'b1};
  assign right_w   = left_w + (AW+2)'(1);
  assign has_left  = left_w < (AW+2)'(count);
  assign has_right = right_w < (AW+2)'(count);

  // ties keep the parent, then the left child
  assign pick_left  = out_of_order(order_is_max, v, lval);
  assign pv         = pick_left ? lval : v;
  assign pick_right = has_right && out_of_order(order_is_max, pv, rdata);
  assign best       = pick_right ? rdata : pv;
  assign pick_idx   = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

  assign full      = count == CW'(DEPTH);
  assign load_acc  = cmd.load_en && in_valid;
  assign emit_done = (CW'(idx) + CW'(1)) == count;
  assign out_take  = out_valid && !out_stall;

  assign stat.last_in     = in_valid && in_word.last;
  assign stat.count_ge2   = count >= CW'(2);
  assign stat.has_left    = has_left;
  assign stat.keep_node   = !pick_left && !pick_right;
  assign stat.parent_zero = parent == '0;
  assign stat.out_free    = cmd.emit_rd && (!out_valid || out_take);
  assign stat.emit_done   = emit_done;

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = v;
    if (load_acc) begin
      we    = !full;
      waddr = count[AW-1:0];
      wdata = in_word.key;
    end else if (cmd.left_rd) begin
      we = !has_left;
    end else if (cmd.decide) begin
      we    = 1'b1;
      wdata = best;
    end
  end

  always_comb begin
    if (cmd.par_rd) begin
      raddr = parent;
    end else if (cmd.left_rd) begin
      raddr = left_w[AW-1:0];
    end else if (cmd.right_rd) begin
      raddr = right_w[AW-1:0];
    end else begin
      raddr = idx;
    end
  end

  hb_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      drop         <= 1'b0;
      order_is_max <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_is_max <= cfg_wr_data;
      end
      if (load_acc) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.emit_cap && emit_done) begin
        count <= '0;
        drop  <= 1'b0;
      end
      if (cmd.emit_cap) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      parent <= AW'(count >> 1) - AW'(1);
      idx    <= '0;
    end
    if (cmd.par_rd) begin
      node <= parent;
    end
    if (cmd.par_cap) begin
      v <= rdata;
    end
    if (cmd.right_rd) begin
      lval <= rdata;
    end
    if (cmd.decide && (pick_left || pick_right)) begin
      node <= pick_idx;
    end
    if (cmd.next_par && parent != '0) begin
      parent <= parent - AW'(1);
    end
    if (cmd.emit_cap) begin
      out_word.heap_key   <= rdata;
      out_word.is_last    <= emit_done;
      out_word.overflowed <= drop;
      if (!emit_done) begin
        idx <= idx + AW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/heap_builder_top.sv
// Heap builder top level: loads keys, heapifies bottom-up, emits heap order.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_stall    in_word    (key, last)
//   out      output     out_valid/out_stall  out_word   (heap_key, is_last, overflowed)
//   cfg      input      cfg_wr_en            cfg_wr_data (order_is_max)
//
// Loading accepts one word per cycle; in_stall is low only while loading.
// The build sifts each parent: read and capture it, then per level read the left
//   child, stopping at a leaf, and the right child and decide, all through the
//   single read port of the key store; emission reads, then captures each word.
// A stalled output word holds emission; the next set loads while the final
//   word still waits. Synchronous reset clears counts, flags and order.
`include "heap_builder_top_defines.svh"

module heap_builder_top #(
  parameter int DEPTH = hb_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hb_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output hb_pkg::out_word_t out_word,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);
  import hb_pkg::*;

  hb_cmd_t  cmd;
  hb_stat_t stat;
  logic     in_take;
  logic     mid_emit;

  assign in_stall = !cmd.load_en;
  assign in_take  = in_valid && !in_stall;
  assign mid_emit = out_valid && !out_word.is_last;

  hb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  hb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_valid    (in_valid),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  `HB_ASSERT_NEXT(a_last_stops_load, in_take && in_word.last, in_stall, "load ran past last word")
  `HB_ASSERT_NOW(a_emit_from_build, $rose(out_valid), $past(in_stall), "emit while loading")
  `HB_ASSERT_NOW(a_no_load_mid_emit, mid_emit, in_stall, "load during emission")

endmodule

>>> bench/heap_builder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the heap builder: random key sets checked against a heap predictor.
module heap_builder_top_tb;
  import hb_pkg::*;

  localparam int STORE_DEPTH  = DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS = 310;
  localparam int SETTLE       = 20;
  localparam int SHOW_LIMIT   = 10;
  localparam logic ORDER_MIN  = 1'b0;
  localparam logic ORDER_MAX  = 1'b1;

  class heap_tracker;
    logic [KEY_WIDTH-1:0] keys[STORE_DEPTH];
    int unsigned held;
    bit dropped;
    bit max_order;
    out_word_t heap_words_q[$];
    int unsigned mismatches;

    function void set_order(bit order_sel);
      max_order = order_sel;
    endfunction

    // parent must give way to child
    function bit wrong_way(logic [KEY_WIDTH-1:0] p, logic [KEY_WIDTH-1:0] c);
      return max_order ? (p < c) : (p > c);
    endfunction

    function void take_key(in_word_t w);
      int p;
      int unsigned node;
      int unsigned pick;
      int unsigned lo;
      int unsigned i;
      logic [KEY_WIDTH-1:0] tmp;
      out_word_t o;
      if (held < STORE_DEPTH) begin
        keys[held] = w.key;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (!w.last) return;
      if (held >= 2) begin
        for (p = (held - 2) / 2; p >= 0; p--) begin
          node = p;
          while (node * 2 + 1 < held) begin
            lo = node * 2 + 1;
            pick = node;
            if (wrong_way(keys[pick], keys[lo])) pick = lo;
            if (lo + 1 < held && wrong_way(keys[pick], keys[lo + 1])) pick = lo + 1;
            if (pick == node) break;
            tmp = keys[node];
            keys[node] = keys[pick];
            keys[pick] = tmp;
            node = pick;
          end
        end
      end
      for (i = 0; i < held; i++) begin
        o.heap_key = keys[i];
        o.is_last = (i + 1 == held);
        o.overflowed = dropped;
        heap_words_q.push_back(o);
      end
      held = 0;
      dropped = 1'b0;
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (heap_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: unexpected word key=%h last=%b ovf=%b", $realtime,
                   got.heap_key, got.is_last, got.overflowed);
        return;
      end
      want = heap_words_q.pop_front();
      if (got.heap_key !== want.heap_key || got.is_last !== want.is_last ||
          got.overflowed !== want.overflowed) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: mismatch exp key=%h last=%b ovf=%b got key=%h last=%b ovf=%b",
                   $realtime, want.heap_key, want.is_last, want.overflowed,
                   got.heap_key, got.is_last, got.overflowed);
      end
    endfunction

    function int unsigned waiting();
      return heap_words_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  logic      calm;

  heap_tracker tracker;
  int unsigned items_sent;

  heap_builder_top #(
    .DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random back-pressure, quiet while calm
  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_word(out_word);
  end

  // called at a falling edge; returns at a falling edge with in_valid still high
  task automatic load_set(input logic [KEY_WIDTH-1:0] ks[$]);
    in_word_t w;
    foreach (ks[i]) begin
      w.key = ks[i];
      w.last = (i == ks.size() - 1);
      while (!calm && $urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_word <= w;
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      tracker.take_key(w);
      items_sent++;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.waiting() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_order(input logic order_sel);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= order_sel;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_order(order_sel);
    @(negedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("heap_builder_top_tb: FAIL");
    $finish;
  end

  initial begin
    logic [KEY_WIDTH-1:0] set_keys[$];
    int unsigned big_q[$];
    int unsigned size;
    int unsigned set_no;
    int unsigned mode;
    int unsigned since_cfg;
    int unsigned cfg_no;

    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    calm = 1'b0;
    tracker = new();
    items_sent = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: single element, pair of extremes, ties, reversed run, max order
    write_order(ORDER_MIN);
    load_set({32'h0});
    load_set({32'hFFFF_FFFF, 32'h0});
    load_set({32'd7, 32'd7, 32'd7, 32'd3, 32'd7});
    load_set({32'd9, 32'd8, 32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1});
    write_order(ORDER_MAX);
    load_set({32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF});

    // random sets; a few hit the full store, exactly and with drops
    big_q = {65, STORE_DEPTH, 70};
    set_no = 0;
    since_cfg = 0;
    cfg_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (since_cfg >= 60) begin
        case (cfg_no % 3)
          0: write_order(ORDER_MIN);
          1: write_order(ORDER_MAX);
          default: write_order(1'($urandom_range(1)));
        endcase
        cfg_no++;
        since_cfg = 0;
      end
      calm <= (set_no >= 12 && set_no < 18);
      if (set_no % 9 == 4 && big_q.size() != 0) size = big_q.pop_front();
      else if ($urandom_range(99) < 10) size = $urandom_range(40, 13);
      else size = $urandom_range(12, 1);
      mode = $urandom_range(3);
      set_keys.delete();
      repeat (size) begin
        case (mode)
          0: set_keys.push_back($urandom);
          1: set_keys.push_back($urandom_range(7));
          2: set_keys.push_back($urandom_range(2) == 0 ? 32'h0 :
                                $urandom_range(1) == 0 ? 32'hFFFF_FFFF : $urandom);
          default: set_keys.push_back({8'($urandom_range(255)), 2'($urandom_range(3)),
                                       22'h0});
        endcase
      end
      load_set(set_keys);
      since_cfg += size;
      set_no++;
    end
    calm <= 1'b0;

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("heap_builder_top_tb: PASS");
    end else begin
      $display("heap_builder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
